// File: hdl/ptmc_pkg.sv
// Shared types and sizing constants for the peak-triggered MLP classifier.
`timescale 1ns / 1ps

package ptmc_pkg;

  localparam int WINDOW_LEN   = 10;
  localparam int HIDDEN_UNITS = 8;
  localparam int CLASS_COUNT  = 3;

  localparam int W1_BASE    = 0;
  localparam int B1_BASE    = WINDOW_LEN * HIDDEN_UNITS;
  localparam int W2_BASE    = B1_BASE + HIDDEN_UNITS;
  localparam int B2_BASE    = W2_BASE + HIDDEN_UNITS * CLASS_COUNT;
  localparam int TABLE_SIZE = B2_BASE + CLASS_COUNT;

  localparam int TBL_AW   = 7;
  localparam int PTR_W    = $clog2(WINDOW_LEN);
  localparam int HID_W    = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int UNIT_MAX = (HIDDEN_UNITS > CLASS_COUNT) ? HIDDEN_UNITS : CLASS_COUNT;
  localparam int UNIT_W   = (UNIT_MAX > 1) ? $clog2(UNIT_MAX) : 1;
  localparam int TERM_MAX = (WINDOW_LEN > HIDDEN_UNITS) ? WINDOW_LEN : HIDDEN_UNITS;
  localparam int TERM_W   = $clog2(TERM_MAX + 1);
  localparam int PROD_W   = 32;
  localparam int ACC_W    = PROD_W + $clog2(TERM_MAX + 1) + 1;

  localparam logic signed [15:0] THRESH_RESET = 16'sd2458;
  localparam logic signed [15:0] BIAS_SCALE   = 16'sd4096;
  localparam logic signed [15:0] ACT_MAX      = 16'sd32767;
  localparam int                 FRAC_BITS    = 12;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_PARAM  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [6:0]         param_index;
    logic signed [15:0] param_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         diagnosis;
    logic signed [15:0] peak_sample;
  } out_word_t;

endpackage

// File: hdl/peak_triggered_mlp_classifier_core.sv
// Top level: ECG sample window, parameter table and shared-MAC MLP sequencer.
`timescale 1ns / 1ps

// Words of kind "parameter write" and samples that are not a peak are
// accepted whenever in_ready_o is high and leave the sequencer idle. A sample
// that is above the threshold thr_q and below the previous sample starts a
// classification: one multiply-accumulate per cycle through a single 16x16
// MAC fed by the one read port of the parameter table, which is
// H*(W+1) + C*(H+1) terms (115 at the default sizes), with the MAC pipeline
// drained after each layer and a handoff state, S_DONE, that raises
// out_valid_o once the output register is free. in_ready_o is low during that
// time; it is high again while the result waits in the output register, but a
// following classification holds at its end until that register is free. The
// table has no reset value: load every weight and bias before the first peak.
module peak_triggered_mlp_classifier_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptmc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptmc_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_L1    = 3'd1;
  localparam logic [2:0] S_L2    = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       layer_q, layer_d;
  logic [ptmc_pkg::UNIT_W-1:0] unit_q, unit_d;
  logic [ptmc_pkg::TERM_W-1:0] term_q, term_d;
  logic [ptmc_pkg::PTR_W-1:0]  ptr_q, slot_q;

  logic signed [15:0] thr_q, prev_q, peak_q;
  logic signed [15:0] window_q [ptmc_pkg::WINDOW_LEN];
  logic signed [15:0] hidden_q [ptmc_pkg::HIDDEN_UNITS];
  logic signed [15:0] mem_q    [ptmc_pkg::TABLE_SIZE];

  logic                         out_valid_q;
  ptmc_pkg::out_word_t          out_q;

  // MAC pipeline: issue -> table read / operand -> product -> accumulate -> finalize
  logic [ptmc_pkg::TBL_AW-1:0]  rd_addr;
  logic signed [15:0]           op_a, a_q, rd_q;
  logic signed [ptmc_pkg::PROD_W-1:0] prod_q;
  logic signed [ptmc_pkg::ACC_W-1:0]  acc_q, best_logit_q, act_q;
  logic [ptmc_pkg::UNIT_W-1:0]  best_q;

  logic                         s1_v_q, s2_v_q, fin_v_q;
  logic                         s1_first_q, s2_first_q;
  logic                         s1_last_q, s2_last_q;
  logic                         s1_lu_q, s2_lu_q, fin_lu_q;
  logic [ptmc_pkg::UNIT_W-1:0]  s1_unit_q, s2_unit_q, fin_unit_q;

  logic in_acc, is_param, is_sample, peak, issuing, last_term, last_unit, fin_done;
  logic [ptmc_pkg::TERM_W-1:0] term_m1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_param   = in_acc && (in_word_i.kind == ptmc_pkg::KIND_PARAM);
  assign is_sample  = in_acc && (in_word_i.kind == ptmc_pkg::KIND_SAMPLE);
  assign peak       = (in_word_i.sample > thr_q) && (in_word_i.sample < prev_q);

  assign issuing   = (state_q == S_L1) || (state_q == S_L2);
  assign term_m1   = term_q - 1'b1;
  assign last_term = layer_q ? (term_q == ptmc_pkg::TERM_W'(ptmc_pkg::HIDDEN_UNITS))
                             : (term_q == ptmc_pkg::TERM_W'(ptmc_pkg::WINDOW_LEN));
  assign last_unit = layer_q ? (unit_q == ptmc_pkg::UNIT_W'(ptmc_pkg::CLASS_COUNT - 1))
                             : (unit_q == ptmc_pkg::UNIT_W'(ptmc_pkg::HIDDEN_UNITS - 1));
  assign fin_done  = fin_v_q && fin_lu_q;

  // term 0 is the bias, scaled up by the multiplier; later terms are weights
  always_comb begin
    if (!layer_q) begin
      if (term_q == '0) begin
        rd_addr = ptmc_pkg::TBL_AW'(ptmc_pkg::B1_BASE) + ptmc_pkg::TBL_AW'(unit_q);
        op_a    = ptmc_pkg::BIAS_SCALE;
      end else begin
        rd_addr = ptmc_pkg::TBL_AW'(ptmc_pkg::W1_BASE)
                + ptmc_pkg::TBL_AW'(term_m1) * ptmc_pkg::TBL_AW'(ptmc_pkg::HIDDEN_UNITS)
                + ptmc_pkg::TBL_AW'(unit_q);
        op_a    = window_q[slot_q];
      end
    end else begin
      if (term_q == '0) begin
        rd_addr = ptmc_pkg::TBL_AW'(ptmc_pkg::B2_BASE) + ptmc_pkg::TBL_AW'(unit_q);
        op_a    = ptmc_pkg::BIAS_SCALE;
      end else begin
        rd_addr = ptmc_pkg::TBL_AW'(ptmc_pkg::W2_BASE)
                + ptmc_pkg::TBL_AW'(term_m1) * ptmc_pkg::TBL_AW'(ptmc_pkg::CLASS_COUNT)
                + ptmc_pkg::TBL_AW'(unit_q);
        op_a    = hidden_q[ptmc_pkg::HID_W'(term_m1)];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    unit_d  = unit_q;
    term_d  = term_q;
    case (state_q)
      S_IDLE: begin
        if (is_sample && peak) begin
          state_d = S_L1;
          layer_d = 1'b0;
          unit_d  = '0;
          term_d  = '0;
        end
      end
      S_L1, S_L2: begin
        if (last_term) begin
          term_d = '0;
          if (last_unit) begin
            unit_d  = '0;
            state_d = S_DRAIN;
          end else begin
            unit_d = unit_q + 1'b1;
          end
        end else begin
          term_d = term_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (fin_done) begin
          if (!layer_q) begin
            layer_d = 1'b1;
            state_d = S_L2;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      layer_q     <= 1'b0;
      unit_q      <= '0;
      term_q      <= '0;
      ptr_q       <= '0;
      prev_q      <= '0;
      thr_q       <= ptmc_pkg::THRESH_RESET;
      out_valid_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      fin_v_q     <= 1'b0;
      for (int k = 0; k < ptmc_pkg::WINDOW_LEN; k++) window_q[k] <= '0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      unit_q  <= unit_d;
      term_q  <= term_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (is_sample) begin
        window_q[ptr_q] <= in_word_i.sample;
        ptr_q  <= (ptr_q == ptmc_pkg::PTR_W'(ptmc_pkg::WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
        prev_q <= in_word_i.sample;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      s1_v_q  <= issuing;
      s2_v_q  <= s1_v_q;
      fin_v_q <= s2_v_q && s2_last_q;
    end
  end

  // parameter table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (is_param && ({1'b0, in_word_i.param_index} < 8'(ptmc_pkg::TABLE_SIZE))) begin
      mem_q[in_word_i.param_index] <= in_word_i.param_value;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign act_q = acc_q >>> ptmc_pkg::FRAC_BITS;

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (is_sample && peak) peak_q <= in_word_i.sample;
    if (issuing && term_q == '0) slot_q <= ptr_q;
    else if (issuing) slot_q <= (slot_q == ptmc_pkg::PTR_W'(ptmc_pkg::WINDOW_LEN - 1))
                                ? '0 : slot_q + 1'b1;

    a_q        <= op_a;
    s1_first_q <= (term_q == '0);
    s1_last_q  <= last_term;
    s1_lu_q    <= last_unit;
    s1_unit_q  <= unit_q;

    prod_q     <= a_q * rd_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_lu_q    <= s1_lu_q;
    s2_unit_q  <= s1_unit_q;

    if (s2_v_q) acc_q <= s2_first_q ? ptmc_pkg::ACC_W'(prod_q)
                                    : acc_q + ptmc_pkg::ACC_W'(prod_q);
    fin_lu_q   <= s2_lu_q;
    fin_unit_q <= s2_unit_q;

    if (fin_v_q) begin
      if (!layer_q) begin
        if (acc_q <= 0) hidden_q[ptmc_pkg::HID_W'(fin_unit_q)] <= '0;
        else if (act_q > ptmc_pkg::ACC_W'(ptmc_pkg::ACT_MAX))
          hidden_q[ptmc_pkg::HID_W'(fin_unit_q)] <= ptmc_pkg::ACT_MAX;
        else hidden_q[ptmc_pkg::HID_W'(fin_unit_q)] <= act_q[15:0];
      end else if (fin_unit_q == '0 || acc_q > best_logit_q) begin
        best_logit_q <= acc_q;
        best_q       <= fin_unit_q;
      end
    end

    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.diagnosis   <= 2'(best_q);
      out_q.peak_sample <= peak_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // a finalized neuron only appears while a classification runs
  a_fin_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q |-> (state_q == S_L1 || state_q == S_L2 || state_q == S_DRAIN))
    else $error("finalize outside a classification");

  // a peak sample starts the hidden layer
  a_peak_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_sample && peak) |=> (state_q == S_L1 && term_q == '0 && unit_q == '0))
    else $error("peak did not start classification");

  // the MAC pipeline is empty by the time the result is handed off
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (!s1_v_q && !s2_v_q && !fin_v_q))
    else $error("result taken with MAC still busy");

endmodule
